>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vssg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vssg_pkg;

    localparam int LEVELS_DEF     = 4;
    localparam int COUNT_BITS_DEF = 16;

    localparam int POS_W        = 32;
    localparam int CAP_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CELL_INDEX_W = 12;
    localparam int STATUS_W     = 2;

    localparam logic signed [POS_W-1:0] BOUND_A_RST = 32'shFFFF_0000;
    localparam logic signed [POS_W-1:0] BOUND_B_RST = 32'sh0001_0000;
    localparam logic [CAP_W-1:0]        CAP_RST     = 16'd20;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACTIVE  = 2'd0,
        ST_VALID   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOUND_X_A = 3'd0,
        REG_BOUND_X_B = 3'd1,
        REG_BOUND_Y_A = 3'd2,
        REG_BOUND_Y_B = 3'd3,
        REG_BOUND_Z_A = 3'd4,
        REG_BOUND_Z_B = 3'd5,
        REG_CAPACITY  = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_DIV,
        CS_READ,
        CS_UPD
    } t_ctrl_state;

    // Controls from the sequencer to each axis locator.
    typedef struct packed {
        logic load;
        logic step;
    } t_axis_ctl;

endpackage
`default_nettype wire

>>> src/voxel_sample_status_grid.sv
// Each item runs a LEVELS-step restoring division per axis, then the read and write-back
// of the cell record in the state memory; o_valid is registered from the write-back.
// No new item is taken until that write-back is done, and busy stays high meanwhile.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous, active low) restores the configuration and control registers, then
// clears all 2^(3*LEVELS) entries of the state memory, one per cycle; busy stays high.
`timescale 1ns / 1ps
`default_nettype none
module voxel_sample_status_grid #(
    parameter int LEVELS     = vssg_pkg::LEVELS_DEF,
    parameter int COUNT_BITS = vssg_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic                                    i_action,
    input  wire logic signed [vssg_pkg::POS_W-1:0]       i_pos_x,
    input  wire logic signed [vssg_pkg::POS_W-1:0]       i_pos_y,
    input  wire logic signed [vssg_pkg::POS_W-1:0]       i_pos_z,
    input  wire logic                                    i_reached,
    input  wire logic                                    i_cfg_we,
    input  wire logic [vssg_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [vssg_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic                                         o_valid,
    output logic                                         o_in_range,
    output logic [vssg_pkg::CELL_INDEX_W-1:0]            o_cell_index,
    output logic [vssg_pkg::STATUS_W-1:0]                o_cell_status,
    output logic                                         o_is_active
);
    import vssg_pkg::*;

    // The state memory holds one record per cell: status, unreached count and
    // reached count, packed from the top bit down.
    localparam int IDX_W  = 3 * LEVELS;
    localparam int CELLS  = 1 << IDX_W;
    localparam int WORD_W = STATUS_W + 2 * COUNT_BITS;
    localparam int STEP_W = $clog2(LEVELS + 1);

    // Configuration registers.
    logic signed [POS_W-1:0] r_bx_a, r_bx_b, r_by_a, r_by_b, r_bz_a, r_bz_b;
    logic [CAP_W-1:0]        r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx_a <= BOUND_A_RST;
            r_bx_b <= BOUND_B_RST;
            r_by_a <= BOUND_A_RST;
            r_by_b <= BOUND_B_RST;
            r_bz_a <= BOUND_A_RST;
            r_bz_b <= BOUND_B_RST;
            r_cap  <= CAP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_BOUND_X_A: r_bx_a <= $signed(i_cfg_data[POS_W-1:0]);
                REG_BOUND_X_B: r_bx_b <= $signed(i_cfg_data[POS_W-1:0]);
                REG_BOUND_Y_A: r_by_a <= $signed(i_cfg_data[POS_W-1:0]);
                REG_BOUND_Y_B: r_by_b <= $signed(i_cfg_data[POS_W-1:0]);
                REG_BOUND_Z_A: r_bz_a <= $signed(i_cfg_data[POS_W-1:0]);
                REG_BOUND_Z_B: r_bz_b <= $signed(i_cfg_data[POS_W-1:0]);
                REG_CAPACITY:  r_cap  <= i_cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: memory clearing pass after reset, then one item at a time.
    t_ctrl_state      r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_clr;
    logic              r_action;
    logic              r_reached;
    t_axis_ctl         axis_ctl;
    logic              accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        busy          = 1'b1;
        axis_ctl.load = 1'b0;
        axis_ctl.step = 1'b0;
        case (r_state)
            CS_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = CS_IDLE;
                end
            end
            CS_IDLE: begin
                busy          = 1'b0;
                axis_ctl.load = start;
                if (start) begin
                    n_state = CS_DIV;
                end
            end
            CS_DIV: begin
                axis_ctl.step = 1'b1;
                if (r_step == STEP_W'(LEVELS - 1)) begin
                    n_state = CS_READ;
                end
            end
            CS_READ: begin
                n_state = CS_UPD;
            end
            CS_UPD: begin
                n_state = CS_IDLE;
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_clr  <= '0;
        end else begin
            if (r_state == CS_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (accept) begin
                r_step <= '0;
            end else if (r_state == CS_DIV) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_reached <= i_reached;
        end
    end

    // One locator per axis; all three run in parallel.
    logic              ok_x, ok_y, ok_z, ok_all;
    logic [LEVELS-1:0] cx, cy, cz;
    logic [IDX_W-1:0]  cell_addr;

    vssg_axis #(.LEVELS(LEVELS)) u_axis_x (
        .i_clk   (i_clk),
        .i_ctl   (axis_ctl),
        .i_pos   (i_pos_x),
        .i_bnd_a (r_bx_a),
        .i_bnd_b (r_bx_b),
        .o_ok    (ok_x),
        .o_cell  (cx)
    );

    vssg_axis #(.LEVELS(LEVELS)) u_axis_y (
        .i_clk   (i_clk),
        .i_ctl   (axis_ctl),
        .i_pos   (i_pos_y),
        .i_bnd_a (r_by_a),
        .i_bnd_b (r_by_b),
        .o_ok    (ok_y),
        .o_cell  (cy)
    );

    vssg_axis #(.LEVELS(LEVELS)) u_axis_z (
        .i_clk   (i_clk),
        .i_ctl   (axis_ctl),
        .i_pos   (i_pos_z),
        .i_bnd_a (r_bz_a),
        .i_bnd_b (r_bz_b),
        .o_ok    (ok_z),
        .o_cell  (cz)
    );

    assign ok_all    = ok_x && ok_y && ok_z;
    assign cell_addr = {cz, cy, cx};

    // State memory. The cell address is held steady from the read cycle through
    // the write-back cycle, and items never overlap, so no forwarding is needed.
    logic [WORD_W-1:0]     rdata;
    logic [WORD_W-1:0]     wdata;
    logic [IDX_W-1:0]      waddr;
    logic                  mem_we;
    t_status               new_status;
    logic [COUNT_BITS-1:0] new_reached;
    logic [COUNT_BITS-1:0] new_unreached;
    logic                  upd_we;

    vssg_update #(.COUNT_BITS(COUNT_BITS)) u_update (
        .i_status        (t_status'(rdata[WORD_W-1 -: STATUS_W])),
        .i_reached_cnt   (rdata[COUNT_BITS-1:0]),
        .i_unreached_cnt (rdata[2*COUNT_BITS-1:COUNT_BITS]),
        .i_sample        (!r_action),
        .i_reached       (r_reached),
        .i_capacity      (r_cap),
        .o_status        (new_status),
        .o_reached_cnt   (new_reached),
        .o_unreached_cnt (new_unreached),
        .o_we            (upd_we)
    );

    always_comb begin
        if (r_state == CS_CLEAR) begin
            mem_we = 1'b1;
            waddr  = r_clr;
            wdata  = '0;
        end else begin
            mem_we = (r_state == CS_UPD) && ok_all && upd_we;
            waddr  = cell_addr;
            wdata  = {new_status, new_unreached, new_reached};
        end
    end

    vssg_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (cell_addr),
        .o_rdata (rdata)
    );

    // Result register: the item's outcome is captured at the end of the
    // write-back cycle and shown for one cycle. An out-of-range point reports
    // all zeros and leaves the memory untouched.
    logic                    r_valid;
    logic                    r_in_range;
    logic [CELL_INDEX_W-1:0] r_cell_index;
    logic [STATUS_W-1:0]     r_cell_status;
    logic                    r_is_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == CS_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CS_UPD) begin
            r_in_range    <= ok_all;
            r_cell_index  <= ok_all ? CELL_INDEX_W'(cell_addr) : '0;
            r_cell_status <= ok_all ? new_status : ST_ACTIVE;
            r_is_active   <= ok_all && (new_status == ST_ACTIVE);
        end
    end

    assign o_valid       = r_valid;
    assign o_in_range    = r_in_range;
    assign o_cell_index  = r_cell_index;
    assign o_cell_status = r_cell_status;
    assign o_is_active   = r_is_active;

endmodule
`default_nettype wire

>>> src/vssg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module vssg_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> src/vssg_axis.sv
`timescale 1ns / 1ps
`default_nettype none
// Locates the cell along one axis. On load the box limits are ordered and
// the offset is formed; each step then produces one quotient bit of
// (offset * 2^LEVELS - 1) / span by restoring division.
module vssg_axis #(
    parameter int LEVELS = vssg_pkg::LEVELS_DEF
) (
    input  wire logic                              i_clk,
    input  vssg_pkg::t_axis_ctl                    i_ctl,
    input  wire logic signed [vssg_pkg::POS_W-1:0] i_pos,
    input  wire logic signed [vssg_pkg::POS_W-1:0] i_bnd_a,
    input  wire logic signed [vssg_pkg::POS_W-1:0] i_bnd_b,
    output logic                                   o_ok,
    output logic [LEVELS-1:0]                      o_cell
);
    import vssg_pkg::*;

    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic [POS_W:0]          rem2;
    logic [POS_W:0]          dext;
    logic                    qbit;

    logic [POS_W-1:0]  r_rem, n_rem;
    logic [POS_W-1:0]  r_d;
    logic [LEVELS-1:0] r_quo, n_quo;
    logic              r_ok;
    logic              r_zero;

    always_comb begin
        lo   = (i_bnd_a < i_bnd_b) ? i_bnd_a : i_bnd_b;
        hi   = (i_bnd_a < i_bnd_b) ? i_bnd_b : i_bnd_a;
        rem2 = {r_rem, 1'b1};
        dext = {1'b0, r_d};
        qbit = (rem2 >= dext);
        n_rem = qbit ? POS_W'(rem2 - dext) : POS_W'(rem2);
        n_quo = LEVELS'({r_quo, qbit});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ok   <= !(i_pos < lo) && !(i_pos > hi);
            r_zero <= (i_pos == lo) || (i_bnd_a == i_bnd_b);
            r_d    <= $unsigned(hi) - $unsigned(lo);
            // offset minus one: pos + ~lo == pos - lo - 1
            r_rem  <= $unsigned(i_pos) + ~$unsigned(lo);
            r_quo  <= '0;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_ok   = r_ok;
    assign o_cell = r_zero ? '0 : r_quo;

endmodule
`default_nettype wire

>>> src/vssg_update.sv
`timescale 1ns / 1ps
`default_nettype none
// Read-modify-write arithmetic for one cell record.
module vssg_update #(
    parameter int COUNT_BITS = vssg_pkg::COUNT_BITS_DEF
) (
    input  vssg_pkg::t_status                i_status,
    input  wire logic [COUNT_BITS-1:0]       i_reached_cnt,
    input  wire logic [COUNT_BITS-1:0]       i_unreached_cnt,
    input  wire logic                        i_sample,
    input  wire logic                        i_reached,
    input  wire logic [vssg_pkg::CAP_W-1:0]  i_capacity,
    output vssg_pkg::t_status                o_status,
    output logic      [COUNT_BITS-1:0]       o_reached_cnt,
    output logic      [COUNT_BITS-1:0]       o_unreached_cnt,
    output logic                             o_we
);
    import vssg_pkg::*;

    localparam int TOT_W = (COUNT_BITS + 1 > CAP_W) ? COUNT_BITS + 1 : CAP_W;
    localparam int CMP_W = COUNT_BITS + 3;

    logic             upd;
    logic [TOT_W-1:0] total;
    logic [CMP_W-1:0] five_u;
    logic [CMP_W-1:0] two_t1;

    always_comb begin
        upd = i_sample && (i_status == ST_ACTIVE);
        o_reached_cnt   = i_reached_cnt;
        o_unreached_cnt = i_unreached_cnt;
        if (upd && i_reached && (i_reached_cnt != '1)) begin
            o_reached_cnt = i_reached_cnt + 1'b1;
        end
        if (upd && !i_reached && (i_unreached_cnt != '1)) begin
            o_unreached_cnt = i_unreached_cnt + 1'b1;
        end
        total  = TOT_W'(o_reached_cnt) + TOT_W'(o_unreached_cnt);
        five_u = (CMP_W'(o_unreached_cnt) << 2) + CMP_W'(o_unreached_cnt);
        two_t1 = (CMP_W'(total) + 1'b1) << 1;
        o_status = i_status;
        if (upd && (total >= TOT_W'(i_capacity))) begin
            o_status = (five_u > two_t1) ? ST_INVALID : ST_VALID;
        end
        o_we = upd;
    end

endmodule
`default_nettype wire

>>> src/vssg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vssg_checker (
    input wire logic                                    i_clk,
    input wire logic                                    i_rst_n,
    input wire logic                                    start,
    input wire logic                                    busy,
    input wire logic                                    o_valid,
    input wire logic                                    o_in_range,
    input wire logic [vssg_pkg::CELL_INDEX_W-1:0]       o_cell_index,
    input wire logic [vssg_pkg::STATUS_W-1:0]           o_cell_status,
    input wire logic                                    o_is_active
);
    import vssg_pkg::*;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while still busy")
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held for two cycles")
    `ASSERT_SAME(a_out_zero, i_clk, i_rst_n, o_valid && !o_in_range, (o_cell_index == '0) && (o_cell_status == ST_ACTIVE) && !o_is_active, "out of range result not cleared")
    `ASSERT_SAME(a_active_flag, i_clk, i_rst_n, o_valid && o_in_range, o_is_active == (o_cell_status == ST_ACTIVE), "active flag disagrees with status")

endmodule

bind voxel_sample_status_grid vssg_checker u_vssg_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for voxel_sample_status_grid.
//
// A behavioral copy of the grid runs next to the block. It keeps its own box
// bounds, capacity and per-cell status and counts. Every item that the block
// accepts is pushed through that copy, and the result it predicts goes into a
// FIFO. Each result strobe from the block is compared against the oldest
// entry of that FIFO.
//
// The run starts with a few directed checks:
//   - cell lookup on the default box;
//   - status classification at the capacity limits;
//   - boxes that are flat, swapped or as wide as the coordinate range.
// After that come random phases. Each phase picks a new box and a new capacity.
// About half the points in a phase land on a handful of repeated spots, so
// cells fill up and get classified. The sender pauses at random, except in the
// last phase, which runs items back to back.
module tb_top;
    import vssg_pkg::*;

    localparam int LEVELS         = LEVELS_DEF;
    localparam int CELLS          = 1 << (3 * LEVELS);
    localparam int LATENCY        = LEVELS + 3;
    // The limit also covers the clearing pass after reset, in which nothing is accepted.
    localparam int WATCHDOG_LIMIT = 4 * CELLS + 2000;
    localparam int HOT_SPOTS      = 4;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                    in_range;
        logic [CELL_INDEX_W-1:0] cell_index;
        logic [STATUS_W-1:0]     cell_status;
        logic                    is_active;
    } voxel_result_t;

    // Clock, reset and all block inputs start at known values.
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    start      = 1'b0;
    logic                    i_action   = 1'b0;
    logic signed [POS_W-1:0] i_pos_x    = '0;
    logic signed [POS_W-1:0] i_pos_y    = '0;
    logic signed [POS_W-1:0] i_pos_z    = '0;
    logic                    i_reached  = 1'b0;
    logic                    i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    logic                    busy;
    logic                    o_valid;
    logic                    o_in_range;
    logic [CELL_INDEX_W-1:0] o_cell_index;
    logic [STATUS_W-1:0]     o_cell_status;
    logic                    o_is_active;

    // The bench's own copy of the grid: configuration plus per-cell records.
    logic signed [POS_W-1:0]   bound_a [3];
    logic signed [POS_W-1:0]   bound_b [3];
    logic [CAP_W-1:0]          capacity;
    t_status                   cell_status_mem [CELLS];
    logic [COUNT_BITS_DEF-1:0] reached_mem [CELLS];
    logic [COUNT_BITS_DEF-1:0] missed_mem [CELLS];

    voxel_result_t expected_voxels [$];

    // Spots that one random phase keeps coming back to, so that cells fill up.
    logic signed [POS_W-1:0] hot_pts [HOT_SPOTS][3];

    bit gaps_on       = 1'b1;
    int error_count   = 0;
    int idle_cycles   = 0;
    int items_sent    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int inside_seen   = 0;
    int valid_seen    = 0;
    int invalid_seen  = 0;
    int box_settings  = 0;

    voxel_sample_status_grid dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_reached     (i_reached),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_in_range    (o_in_range),
        .o_cell_index  (o_cell_index),
        .o_cell_status (o_cell_status),
        .o_is_active   (o_is_active)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Finds the cell of one coordinate along one axis.
    // The return value is 0 when p lies outside the closed interval.
    // The cell number is the count of inner cell boundaries that lie strictly
    // below p. So a point that sits exactly on a boundary goes to the lower
    // cell. A flat interval, or p on the low bound, gives cell 0.
    function automatic bit locate_axis(input logic signed [POS_W-1:0] p,
                                       input logic signed [POS_W-1:0] a,
                                       input logic signed [POS_W-1:0] b,
                                       output logic [LEVELS-1:0] cell_num);
        longint lo, hi, pp;
        longint unsigned span, off, scaled;
        lo       = (a < b) ? a : b;
        hi       = (a < b) ? b : a;
        pp       = p;
        cell_num = '0;
        if (pp < lo || pp > hi) begin
            return 1'b0;
        end
        span = hi - lo;
        off  = pp - lo;
        if (off == 0 || span == 0) begin
            return 1'b1;
        end
        scaled   = off << LEVELS;
        cell_num = LEVELS'((scaled - 1) / span);
        return 1'b1;
    endfunction

    // Applies one item to the copy of the grid and returns the result that
    // the block should report for it.
    function automatic voxel_result_t voxel_update(input logic act,
                                                   input logic signed [POS_W-1:0] px,
                                                   input logic signed [POS_W-1:0] py,
                                                   input logic signed [POS_W-1:0] pz,
                                                   input logic rch);
        logic [LEVELS-1:0]       cx, cy, cz;
        logic [CELL_INDEX_W-1:0] idx;
        longint unsigned         total, missed;
        bit                      ok_x, ok_y, ok_z;
        voxel_result_t           res;
        res  = '0;
        ok_x = locate_axis(px, bound_a[0], bound_b[0], cx);
        ok_y = locate_axis(py, bound_a[1], bound_b[1], cy);
        ok_z = locate_axis(pz, bound_a[2], bound_b[2], cz);
        if (!(ok_x && ok_y && ok_z)) begin
            return res;
        end
        idx = {cz, cy, cx};
        // Only an active cell takes samples. The counters stop at their maximum.
        if (act == ACT_SAMPLE && cell_status_mem[idx] == ST_ACTIVE) begin
            if (rch) begin
                if (reached_mem[idx] != COUNT_MAX) begin
                    reached_mem[idx] = reached_mem[idx] + 1'b1;
                end
            end else begin
                if (missed_mem[idx] != COUNT_MAX) begin
                    missed_mem[idx] = missed_mem[idx] + 1'b1;
                end
            end
            missed = missed_mem[idx];
            total  = reached_mem[idx] + missed;
            // When the total reaches capacity, the cell is invalid if the share of
            // unreached samples, counted against total + 1, is above 0.4.
            // Otherwise the cell is valid.
            if (total >= capacity) begin
                cell_status_mem[idx] = (5 * missed > 2 * (total + 1)) ? ST_INVALID : ST_VALID;
            end
        end
        res.in_range    = 1'b1;
        res.cell_index  = idx;
        res.cell_status = cell_status_mem[idx];
        res.is_active   = (cell_status_mem[idx] == ST_ACTIVE);
        return res;
    endfunction

    // A point in cell k of every axis of the default box, near the cell's low edge.
    function automatic logic signed [POS_W-1:0] cell_pos(input int k);
        return -65536 + k * 8192 + 100;
    endfunction

    // Picks one coordinate for an axis of the current box. With in_box set, the
    // value always lies inside the box. Otherwise the value may fall in the box,
    // on or next to a cell boundary, on a bound, or anywhere in the 32-bit range.
    function automatic logic signed [POS_W-1:0] axis_point(input int axis, input bit in_box);
        longint          lo, hi, pt;
        longint unsigned span;
        int              pick;
        lo   = (bound_a[axis] < bound_b[axis]) ? bound_a[axis] : bound_b[axis];
        hi   = (bound_a[axis] < bound_b[axis]) ? bound_b[axis] : bound_a[axis];
        span = hi - lo;
        pick = in_box ? 0 : $urandom_range(0, 99);
        if (pick < 60) begin
            pt = lo + longint'({$urandom, $urandom} % (span + 1));
        end else if (pick < 85) begin
            pt = lo + longint'((span * $urandom_range(0, 1 << LEVELS)) >> LEVELS)
                 + longint'($urandom_range(0, 2)) - 1;
        end else if (pick < 93) begin
            pt = $signed($urandom);
        end else begin
            pt = ($urandom_range(0, 1) ? hi : lo) + longint'($urandom_range(0, 2)) - 1;
        end
        return pt[POS_W-1:0];
    endfunction

    // Sends one item to the block. The item is accepted at the edge where
    // busy is low. start stays high after acceptance, so the next item can
    // follow with no idle cycle in between. It is dropped only for a random
    // pause, or when the bench waits for the block to go idle.
    task automatic send_item(input logic act,
                             input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic signed [POS_W-1:0] pz,
                             input logic rch);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        i_pos_x   <= px;
        i_pos_y   <= py;
        i_pos_z   <= pz;
        i_reached <= rch;
        do @(posedge i_clk); while (busy);
        expected_voxels.push_back(voxel_update(act, px, py, pz, rch));
        items_sent++;
        if (act == ACT_SAMPLE) begin
            samples_sent++;
        end
    endtask

    // Lets all outstanding items finish before the configuration changes.
    task automatic drain_grid();
        start <= 1'b0;
        while (expected_voxels.size() != 0 || busy) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        drain_grid();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_BOUND_X_A: bound_a[0] = value;
            REG_BOUND_X_B: bound_b[0] = value;
            REG_BOUND_Y_A: bound_a[1] = value;
            REG_BOUND_Y_B: bound_b[1] = value;
            REG_BOUND_Z_A: bound_a[2] = value;
            REG_BOUND_Z_B: bound_b[2] = value;
            REG_CAPACITY:  capacity   = value[CAP_W-1:0];
            default: ;
        endcase
    endtask

    // Writes both bounds of one axis, in random order.
    task automatic set_axis(input t_cfg_reg reg_a, input t_cfg_reg reg_b,
                            input logic signed [POS_W-1:0] va,
                            input logic signed [POS_W-1:0] vb);
        if ($urandom_range(0, 1)) begin
            write_reg(reg_a, va);
            write_reg(reg_b, vb);
        end else begin
            write_reg(reg_b, vb);
            write_reg(reg_a, va);
        end
    endtask

    // Lookup on the reset box [-1.0, 1.0]. The checks cover the center, both
    // corners, the point just past the midpoint, and points outside the box,
    // including the ends of the 32-bit range.
    task automatic test_default_box();
        send_item(ACT_QUERY, 0, 0, 0, 1'b0);
        send_item(ACT_QUERY, -65536, -65536, -65536, 1'b1);
        send_item(ACT_QUERY, 65536, 65536, 65536, 1'b0);
        send_item(ACT_QUERY, 1, 1, 1, 1'b1);
        send_item(ACT_SAMPLE, 65537, 0, 0, 1'b1);
        send_item(ACT_SAMPLE, 0, -65537, 0, 1'b0);
        send_item(ACT_SAMPLE, POS_MAX, POS_MIN, 0, 1'b1);
        send_item(ACT_QUERY, 0, 0, POS_MIN, 1'b1);
    endtask

    // With capacity zero, the first sample in a cell classifies it, and later
    // samples change nothing. With capacity four, two reached and two unreached
    // samples sit exactly on the 0.4 limit, so the cell becomes valid.
    task automatic test_classification();
        write_reg(REG_CAPACITY, '0);
        send_item(ACT_SAMPLE, cell_pos(3), cell_pos(3), cell_pos(3), 1'b1);
        send_item(ACT_SAMPLE, cell_pos(4), cell_pos(4), cell_pos(4), 1'b0);
        send_item(ACT_SAMPLE, cell_pos(3), cell_pos(3), cell_pos(3), 1'b0);
        send_item(ACT_QUERY, cell_pos(4), cell_pos(4), cell_pos(4), 1'b1);
        write_reg(REG_CAPACITY, 16'd4);
        send_item(ACT_SAMPLE, cell_pos(10), cell_pos(2), cell_pos(5), 1'b1);
        send_item(ACT_SAMPLE, cell_pos(10), cell_pos(2), cell_pos(5), 1'b1);
        send_item(ACT_SAMPLE, cell_pos(10), cell_pos(2), cell_pos(5), 1'b0);
        send_item(ACT_SAMPLE, cell_pos(10), cell_pos(2), cell_pos(5), 1'b0);
    endtask

    // Three unusual boxes: a flat x axis, a y axis whose bounds are given in
    // reverse order, and a z axis that spans the whole coordinate range.
    task automatic test_odd_boxes();
        set_axis(REG_BOUND_X_A, REG_BOUND_X_B, 12345, 12345);
        set_axis(REG_BOUND_Y_A, REG_BOUND_Y_B, 65536, -65536);
        set_axis(REG_BOUND_Z_A, REG_BOUND_Z_B, POS_MIN, POS_MAX);
        box_settings++;
        send_item(ACT_SAMPLE, 12345, 0, POS_MIN, 1'b1);
        send_item(ACT_QUERY, 12346, 0, 0, 1'b0);
        send_item(ACT_QUERY, 12345, -65536, POS_MAX, 1'b1);
        send_item(ACT_QUERY, 12345, 65536, 0, 1'b0);
    endtask

    // One random phase.
    // Setup: a new box for every axis, then the given capacity, then a few hot
    // spots and a bias toward reached or unreached samples.
    // Traffic: about half of the points repeat one of the hot spots. The rest
    // are spread across the box and its surroundings.
    task automatic test_random_traffic(input int n_items, input logic [CAP_W-1:0] cap,
                                       input bit allow_gaps);
        logic signed [POS_W-1:0] va, vb, px, py, pz;
        logic                    act, rch;
        int                      reach_pct, h;
        for (int axis = 0; axis < 3; axis++) begin
            case ($urandom_range(0, 4))
                0: begin va = BOUND_A_RST;  vb = BOUND_B_RST; end
                1: begin va = POS_MIN;      vb = POS_MAX; end
                2: begin va = $urandom;     vb = va; end
                3: begin va = $urandom;     vb = $urandom; end
                default: begin
                    va = $urandom;
                    vb = va + $urandom_range(1, 40);
                end
            endcase
            if ($urandom_range(0, 1)) begin
                {va, vb} = {vb, va};
            end
            case (axis)
                0:       set_axis(REG_BOUND_X_A, REG_BOUND_X_B, va, vb);
                1:       set_axis(REG_BOUND_Y_A, REG_BOUND_Y_B, va, vb);
                default: set_axis(REG_BOUND_Z_A, REG_BOUND_Z_B, va, vb);
            endcase
        end
        write_reg(REG_CAPACITY, cap);
        box_settings++;
        for (int s = 0; s < HOT_SPOTS; s++) begin
            for (int axis = 0; axis < 3; axis++) begin
                hot_pts[s][axis] = axis_point(axis, 1'b1);
            end
        end
        reach_pct = $urandom_range(15, 85);
        for (int i = 0; i < n_items; i++) begin
            // Pauses come in stretches, with stretches of none in between.
            if (i % 40 == 0) begin
                gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 45) begin
                h  = $urandom_range(0, HOT_SPOTS - 1);
                px = hot_pts[h][0];
                py = hot_pts[h][1];
                pz = hot_pts[h][2];
            end else begin
                px = axis_point(0, 1'b0);
                py = axis_point(1, 1'b0);
                pz = axis_point(2, 1'b0);
            end
            act = ($urandom_range(0, 99) < 70) ? ACT_SAMPLE : ACT_QUERY;
            rch = ($urandom_range(0, 99) < reach_pct);
            send_item(act, px, py, pz, rch);
        end
    endtask

    // Result checker. A result is taken on the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        voxel_result_t got, want;
        if (i_rst_n && o_valid) begin
            got = {o_in_range, o_cell_index, o_cell_status, o_is_active};
            results_seen++;
            if (o_in_range) begin
                inside_seen++;
            end
            if (o_cell_status == ST_VALID) begin
                valid_seen++;
            end
            if (o_cell_status == ST_INVALID) begin
                invalid_seen++;
            end
            if (expected_voxels.size() == 0) begin
                if (error_count < 10) begin
                    $display("%0t: result with no item outstanding: in_range %0b cell %0h",
                             $time, got.in_range, got.cell_index);
                end
                error_count++;
            end else begin
                want = expected_voxels.pop_front();
                if (got !== want) begin
                    if (error_count < 10) begin
                        $display("%0t: mismatch (expected/actual) in_range %0b/%0b cell %0h/%0h",
                                 $time, want.in_range, got.in_range,
                                 want.cell_index, got.cell_index);
                        $display("    status %0d/%0d active %0b/%0b",
                                 want.cell_status, got.cell_status,
                                 want.is_active, got.is_active);
                    end
                    error_count++;
                end
            end
        end
    end

    // Watchdog. Reset, an accepted item and a result strobe all count as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles without progress", WATCHDOG_LIMIT);
        $display("voxel_sample_status_grid regression: fail");
        $finish;
    end

    initial begin
        // The copy of the grid starts in the state that the block has after
        // reset and after its clearing pass.
        for (int c = 0; c < CELLS; c++) begin
            cell_status_mem[c] = ST_ACTIVE;
            reached_mem[c]     = '0;
            missed_mem[c]      = '0;
        end
        for (int axis = 0; axis < 3; axis++) begin
            bound_a[axis] = BOUND_A_RST;
            bound_b[axis] = BOUND_B_RST;
        end
        capacity = CAP_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_box();
        test_classification();
        test_odd_boxes();
        test_random_traffic(200, 16'hFFFF, 1'b1);
        test_random_traffic(200, 16'($urandom_range(1, 6)), 1'b1);
        test_random_traffic(200, CAP_RST, 1'b1);
        test_random_traffic(200, 16'd0, 1'b1);
        test_random_traffic(200, 16'($urandom_range(1, 40)), 1'b1);
        // The last phase sends items back to back.
        test_random_traffic(150, 16'($urandom_range(2, 10)), 1'b0);

        start <= 1'b0;
        for (int n = 0; n < 100 * LATENCY && expected_voxels.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (expected_voxels.size() != 0) begin
            $display("%0d results never arrived", expected_voxels.size());
            error_count++;
        end

        $display("Sent %0d items (%0d samples) across %0d box settings; %0d results checked.",
                 items_sent, samples_sent, box_settings, results_seen);
        $display("Results: %0d inside the box, %0d valid, %0d invalid; %0d mismatches.",
                 inside_seen, valid_seen, invalid_seen, error_count);
        if (error_count == 0) begin
            $display("voxel_sample_status_grid regression: pass");
        end else begin
            $display("voxel_sample_status_grid regression: fail");
        end
        $finish;
    end
endmodule
